// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  // Default sizing of the queue.
  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  // Fixed field widths of the request and result channels.
  localparam int MODE_W   = 3;
  localparam int TAG_IN_W = 16;
  localparam int ART_W    = 8;
  localparam int CLS_W    = 3;
  localparam int KEY_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Request operation codes.
  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_INSERT    = 3'd2,
    OP_POP       = 3'd3,
    OP_PEEK      = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH_TAIL,
    CMD_PUSH_HEAD,
    CMD_FULL,
    CMD_EMPTY,
    CMD_PEEK,
    CMD_POP,
    CMD_SCAN_START,
    CMD_SCAN_NEXT,
    CMD_SCAN_FOUND,
    CMD_SCAN_END,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_PLACE,
    CMD_PUBLISH
  } dp_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              single;
    logic              before_head;
    logic              key_greater;
    logic              scan_last;
    logic              shift_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/spq_datapath.sv =====
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::dp_cmd_t              cmd,
  output spq_pkg::dp_status_t           dp_st,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic [spq_pkg::MODE_W-1:0]    in_mode,
  input  logic [spq_pkg::TAG_IN_W-1:0]  in_entry_tag,
  input  logic [spq_pkg::ART_W-1:0]     in_article_count,
  input  logic [spq_pkg::CLS_W-1:0]     in_customer_class,
  output logic                          out_head_valid,
  output logic [spq_pkg::TAG_IN_W-1:0]  out_head_tag,
  output logic [spq_pkg::ART_W-1:0]     out_head_articles,
  output logic [spq_pkg::CLS_W-1:0]     out_head_class,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = PTR_W + 2;
  localparam int ENTRY_W = TAG_BITS + ART_W + CLS_W;

  // Entry store, a circular buffer with the head at head_r.
  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rdata_r;

  logic               order_r, order_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [MODE_W-1:0]   mode_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [ART_W-1:0]    art_r;
  logic [CLS_W-1:0]    cls_r;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;

  logic                res_hv_r, res_hv_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic [ART_W-1:0]    res_art_r, res_art_nxt;
  logic [CLS_W-1:0]    res_cls_r, res_cls_nxt;
  status_t             res_st_r, res_st_nxt;

  logic                out_hv_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [ART_W-1:0]    out_art_r;
  logic [CLS_W-1:0]    out_cls_r;
  status_t             out_st_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic [CNT_W-1:0]   rd_lidx;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] new_entry;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   head_dec;

  logic [TAG_BITS-1:0] rd_tag;
  logic [ART_W-1:0]    rd_art;
  logic [CLS_W-1:0]    rd_cls;
  logic [KEY_W-1:0]    rd_key;
  logic [KEY_W-1:0]    new_key;

  // Physical slot of a logical position counted from the head.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

  // Ordering key of an entry under the current configuration.
  function automatic logic [KEY_W-1:0] key_of(input logic by_type,
                                              input logic [ART_W-1:0] art,
                                              input logic [CLS_W-1:0] cls);
    return by_type ? KEY_W'(cls) : KEY_W'(art);
  endfunction

  // Fields of the entry read last cycle, and the keys being compared.
  assign rd_tag    = rdata_r[ENTRY_W-1 -: TAG_BITS];
  assign rd_art    = rdata_r[CLS_W +: ART_W];
  assign rd_cls    = rdata_r[CLS_W-1:0];
  assign rd_key    = key_of(order_r, rd_art, rd_cls);
  assign new_key   = key_of(order_r, art_r, cls_r);
  assign new_entry = {tag_r, art_r, cls_r};

  assign head_inc = (head_r == PTR_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_W'(CAPACITY - 1) : head_r - 1'b1;

  // Status towards the controller.
  always_comb begin
    dp_st.mode        = mode_r;
    dp_st.full        = (count_r == CNT_W'(CAPACITY));
    dp_st.empty       = (count_r == '0);
    dp_st.single      = (count_r == CNT_W'(1));
    dp_st.before_head = (new_key < rd_key);
    dp_st.key_greater = (rd_key > new_key);
    dp_st.scan_last   = (CNT_W'(idx_r + 1'b1) == count_r);
    dp_st.shift_last  = (CNT_W'(idx_r - 1'b1) == pos_r);
  end

  // Read address: the head unless a scan or shift asks for another slot.
  always_comb begin
    case (cmd)
      CMD_SCAN_START: rd_lidx = CNT_W'(1);
      CMD_SCAN_NEXT:  rd_lidx = CNT_W'(idx_r + 1'b1);
      CMD_SHIFT_RD:   rd_lidx = CNT_W'(idx_r - 1'b1);
      default:        rd_lidx = '0;
    endcase
    rd_addr = phys(head_r, rd_lidx);
  end

  // Write port.
  always_comb begin
    we      = 1'b0;
    wr_addr = phys(head_r, count_r);
    wdata   = new_entry;
    case (cmd)
      CMD_PUSH_TAIL: begin
        we = 1'b1;
      end
      CMD_PUSH_HEAD: begin
        we      = 1'b1;
        wr_addr = head_dec;
      end
      CMD_SHIFT_WR: begin
        we      = 1'b1;
        wr_addr = phys(head_r, idx_r);
        wdata   = rdata_r;
      end
      CMD_PLACE: begin
        we      = 1'b1;
        wr_addr = phys(head_r, pos_r);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Next values of the queue state, the scan indexes and the staged result.
  always_comb begin
    order_nxt   = cfg_we ? cfg_data : order_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    res_hv_nxt  = res_hv_r;
    res_tag_nxt = res_tag_r;
    res_art_nxt = res_art_r;
    res_cls_nxt = res_cls_r;
    res_st_nxt  = res_st_r;
    case (cmd) inside
      CMD_LOAD: begin
        res_hv_nxt  = 1'b0;
        res_tag_nxt = '0;
        res_art_nxt = '0;
        res_cls_nxt = '0;
        res_st_nxt  = ST_OK;
      end
      CMD_PUSH_TAIL, CMD_PLACE: begin
        count_nxt = count_r + 1'b1;
      end
      CMD_PUSH_HEAD: begin
        head_nxt  = head_dec;
        count_nxt = count_r + 1'b1;
      end
      CMD_FULL: begin
        res_st_nxt = ST_FULL;
      end
      CMD_EMPTY: begin
        res_st_nxt = ST_EMPTY;
      end
      CMD_PEEK, CMD_POP: begin
        res_hv_nxt  = 1'b1;
        res_tag_nxt = rd_tag;
        res_art_nxt = rd_art;
        res_cls_nxt = rd_cls;
        if (cmd == CMD_POP) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_SCAN_START: begin
        idx_nxt = CNT_W'(1);
      end
      CMD_SCAN_NEXT: begin
        idx_nxt = CNT_W'(idx_r + 1'b1);
      end
      CMD_SCAN_FOUND: begin
        pos_nxt = idx_r;
        idx_nxt = count_r;
      end
      CMD_SCAN_END: begin
        pos_nxt = count_r;
      end
      CMD_SHIFT_WR: begin
        idx_nxt = CNT_W'(idx_r - 1'b1);
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      order_r <= order_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Request capture, scan indexes and result registers.
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      mode_r <= in_mode;
      tag_r  <= TAG_BITS'(in_entry_tag);
      art_r  <= in_article_count;
      cls_r  <= in_customer_class;
    end
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    res_hv_r  <= res_hv_nxt;
    res_tag_r <= res_tag_nxt;
    res_art_r <= res_art_nxt;
    res_cls_r <= res_cls_nxt;
    res_st_r  <= res_st_nxt;
    if (cmd == CMD_PUBLISH) begin
      out_hv_r  <= res_hv_r;
      out_tag_r <= res_tag_r;
      out_art_r <= res_art_r;
      out_cls_r <= res_cls_r;
      out_st_r  <= res_st_r;
      out_occ_r <= OCC_W'(count_r);
    end
  end

  assign out_head_valid    = out_hv_r;
  assign out_head_tag      = TAG_IN_W'(out_tag_r);
  assign out_head_articles = out_art_r;
  assign out_head_class    = out_cls_r;
  assign out_status        = out_st_r;
  assign out_occupancy     = out_occ_r;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spq_pkg::dp_status_t dp_st,
  output spq_pkg::dp_cmd_t    cmd
);
  import spq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dp_st.mode == OP_INSERT && !dp_st.full && !dp_st.empty &&
            !dp_st.before_head && !dp_st.single) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (dp_st.key_greater) begin
          state_nxt = S_SHIFT_RD;
        end else if (dp_st.scan_last) begin
          state_nxt = S_PLACE;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_nxt = dp_st.shift_last ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath commands and request handshake.
  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LOAD;
        end
      end
      S_DECODE: begin
        unique case (dp_st.mode)
          OP_PUSH_TAIL: cmd = dp_st.full ? CMD_FULL : CMD_PUSH_TAIL;
          OP_PUSH_HEAD: cmd = dp_st.full ? CMD_FULL : CMD_PUSH_HEAD;
          OP_INSERT: begin
            if (dp_st.full) begin
              cmd = CMD_FULL;
            end else if (dp_st.empty || dp_st.before_head) begin
              cmd = CMD_PUSH_HEAD;
            end else if (dp_st.single) begin
              cmd = CMD_PUSH_TAIL;
            end else begin
              cmd = CMD_SCAN_START;
            end
          end
          OP_POP:  cmd = dp_st.empty ? CMD_EMPTY : CMD_POP;
          OP_PEEK: cmd = dp_st.empty ? CMD_EMPTY : CMD_PEEK;
          default: cmd = CMD_NONE;
        endcase
      end
      S_SCAN: begin
        if (dp_st.key_greater) begin
          cmd = CMD_SCAN_FOUND;
        end else if (dp_st.scan_last) begin
          cmd = CMD_SCAN_END;
        end else begin
          cmd = CMD_SCAN_NEXT;
        end
      end
      S_SHIFT_RD: cmd = CMD_SHIFT_RD;
      S_SHIFT_WR: cmd = CMD_SHIFT_WR;
      S_PLACE:    cmd = CMD_PLACE;
      S_FIN: begin
        if (out_free) begin
          cmd = CMD_PUBLISH;
        end
      end
      default: cmd = CMD_NONE;
    endcase
  end

  // The result register is full from publication until it is taken.
  always_comb begin
    if (cmd == CMD_PUBLISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Push, pop, peek, spare modes, errors and unscanned inserts pass from acceptance via
// decode to publication; a scanning insert also scans, shifts the later entries back one
// slot by a read and a write each, and places the new entry. Memory scan and shift set
// insert time. One request at a time; the next is taken the cycle after a result is
// registered, even while that result still waits. Synchronous active-low reset empties
// the queue, clears the key select and the output valid and idles the controller.
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spq_pkg::MODE_W-1:0]    in_mode,
  input  logic [spq_pkg::TAG_IN_W-1:0]  in_entry_tag,
  input  logic [spq_pkg::ART_W-1:0]     in_article_count,
  input  logic [spq_pkg::CLS_W-1:0]     in_customer_class,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_head_valid,
  output logic [spq_pkg::TAG_IN_W-1:0]  out_head_tag,
  output logic [spq_pkg::ART_W-1:0]     out_head_articles,
  output logic [spq_pkg::CLS_W-1:0]     out_head_class,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_st;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_st     (dp_st),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .dp_st             (dp_st),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_mode           (in_mode),
    .in_entry_tag      (in_entry_tag),
    .in_article_count  (in_article_count),
    .in_customer_class (in_customer_class),
    .out_head_valid    (out_head_valid),
    .out_head_tag      (out_head_tag),
    .out_head_articles (out_head_articles),
    .out_head_class    (out_head_class),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

endmodule

// ===== hw/rtl/spq_checker.sv =====
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_head_valid,
  input logic [spq_pkg::TAG_IN_W-1:0]  out_head_tag,
  input logic [spq_pkg::ART_W-1:0]     out_head_articles,
  input logic [spq_pkg::CLS_W-1:0]     out_head_class,
  input logic [spq_pkg::STATUS_W-1:0]  out_status,
  input logic [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  // A result never reports more entries than the queue can hold.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_occupancy) <= CAPACITY))
    else $error("occupancy above capacity");

  // An entry is only returned by a request that succeeded.
  a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_valid) |-> (out_status == ST_OK))
    else $error("head entry returned with an error status");

  // Without a returned entry the head fields read as zero.
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |->
      (out_head_tag == '0 && out_head_articles == '0 && out_head_class == '0))
    else $error("head fields not zero without a head entry");

  // A stalled result stays valid and holds its tag, status and occupancy.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_head_tag) && $stable(out_status) &&
       $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// ===== tb/sv/sorted_priority_queue_top_tb.sv =====
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH   = CAPACITY_DEF;
  localparam int MAX_WAIT      = 12;
  localparam int SETTLE_CYCLES = 3 * QUEUE_DEPTH + 12;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_REPORTS   = 10;

  // Mode codes that the block treats as no operation.
  localparam logic [MODE_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [TAG_IN_W-1:0] tag;
    logic [ART_W-1:0]    articles;
    logic [CLS_W-1:0]    cls;
  } entry_t;

  typedef struct packed {
    logic                head_valid;
    logic [TAG_IN_W-1:0] head_tag;
    logic [ART_W-1:0]    head_articles;
    logic [CLS_W-1:0]    head_class;
    status_t             status;
    logic [OCC_W-1:0]    occupancy;
  } reply_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    entry_t            entry;
    logic              typed_in;
    reply_t            reply;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [TAG_IN_W-1:0]  in_entry_tag = '0;
  logic [ART_W-1:0]     in_article_count = '0;
  logic [CLS_W-1:0]     in_customer_class = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_head_valid;
  logic [TAG_IN_W-1:0]  out_head_tag;
  logic [ART_W-1:0]     out_head_articles;
  logic [CLS_W-1:0]     out_head_class;
  logic [STATUS_W-1:0]  out_status;
  logic [OCC_W-1:0]     out_occupancy;

  // Own copy of the queue contents and of the key select.
  entry_t held_entries[$];
  bit     key_by_class;
  reply_t pending_replies[$];
  int     fault_count;
  bit     steady;

  sorted_priority_queue_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_entry_tag      (in_entry_tag),
    .in_article_count  (in_article_count),
    .in_customer_class (in_customer_class),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_head_valid    (out_head_valid),
    .out_head_tag      (out_head_tag),
    .out_head_articles (out_head_articles),
    .out_head_class    (out_head_class),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The ordering key of an entry under the current key select.
  function automatic logic [KEY_W-1:0] sort_key(entry_t e);
    return key_by_class ? KEY_W'(e.cls) : e.articles;
  endfunction

  // Applies one request to the held entries and returns the reply it gives.
  function automatic reply_t serve_request(logic [MODE_W-1:0] mode, entry_t e);
    reply_t r;
    int     pos;
    r = '0;
    case (mode) inside
      OP_PUSH_TAIL, OP_PUSH_HEAD, OP_INSERT: begin
        if (held_entries.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (mode == OP_PUSH_TAIL) begin
          held_entries.push_back(e);
        end else if (mode == OP_PUSH_HEAD) begin
          held_entries.push_front(e);
        end else begin
          // A key below the head's goes in front; otherwise it goes before the first
          // entry after the head whose key is greater, so ties keep arrival order.
          if (held_entries.size() == 0 || sort_key(e) < sort_key(held_entries[0])) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < held_entries.size() && sort_key(held_entries[pos]) <= sort_key(e))
              pos++;
          end
          held_entries.insert(pos, e);
        end
      end
      OP_POP, OP_PEEK: begin
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_valid    = 1'b1;
          r.head_tag      = held_entries[0].tag;
          r.head_articles = held_entries[0].articles;
          r.head_class    = held_entries[0].cls;
          if (mode == OP_POP) void'(held_entries.pop_front());
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(held_entries.size());
    return r;
  endfunction

  // Wait drawn per request or reply; none at all during a steady stretch.
  function automatic int draw_wait();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic step_t step(logic [MODE_W-1:0] mode, logic [TAG_IN_W-1:0] tag,
                                 logic [ART_W-1:0] art, logic [CLS_W-1:0] cls,
                                 logic typed_in, reply_t reply);
    step_t s;
    s.mode     = mode;
    s.entry    = '{tag: tag, articles: art, cls: cls};
    s.typed_in = typed_in;
    s.reply    = reply;
    return s;
  endfunction

  function automatic reply_t reply_of(logic hv, logic [TAG_IN_W-1:0] tag,
                                      logic [ART_W-1:0] art, logic [CLS_W-1:0] cls,
                                      status_t st, logic [OCC_W-1:0] occ);
    reply_t r;
    r.head_valid    = hv;
    r.head_tag      = tag;
    r.head_articles = art;
    r.head_class    = cls;
    r.status        = st;
    r.occupancy     = occ;
    return r;
  endfunction

  // Random entry; narrow article ranges and the extremes give plenty of ties.
  function automatic entry_t random_entry();
    entry_t e;
    e.tag = TAG_IN_W'($urandom);
    case ($urandom_range(0, 3))
      0:       e.articles = ART_W'($urandom_range(0, 3));
      1:       e.articles = $urandom_range(0, 1) ? '1 : '0;
      default: e.articles = ART_W'($urandom_range(0, 255));
    endcase
    e.cls = CLS_W'($urandom_range(0, 7));
    return e;
  endfunction

  // Mostly inserts or removals as the bias says, with a few spare modes.
  function automatic logic [MODE_W-1:0] random_mode(int fill_bias);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return MODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (roll < 3 + fill_bias) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) return OP_INSERT;
      return (roll < 8) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
    end
    return ($urandom_range(0, 9) < 7) ? OP_POP : OP_PEEK;
  endfunction

  task automatic note_fault(string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  // Offers one request and records the reply it must give once accepted.
  task automatic send_request(logic [MODE_W-1:0] mode, entry_t e, logic typed_in,
                              reply_t typed_reply);
    int     gap;
    reply_t modelled;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= mode;
    in_entry_tag      <= e.tag;
    in_article_count  <= e.articles;
    in_customer_class <= e.cls;
    do @(posedge clk); while (!in_ready);
    modelled = serve_request(mode, e);
    pending_replies.push_back(typed_in ? typed_reply : modelled);
  endtask

  // Holds off new requests until every outstanding reply has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_order(bit by_class);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= by_class;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    key_by_class = by_class;
  endtask

  // Request side: reset, directed table, a fill to capacity, then random phases.
  initial begin : request_source
    step_t  table_rows[$];
    reply_t none;
    int     fill_bias;
    bit     order_plan [PHASES];
    none = '0;
    order_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    key_by_class = 1'b0;
    steady = 1'b0;
    fault_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_order(1'b0);

    // Empty queue, spare modes, the extremes of the fields and key ties.
    table_rows.push_back(step(OP_PEEK, '0, '0, '0, 1'b1, reply_of(0, 0, 0, 0, ST_EMPTY, 0)));
    table_rows.push_back(step(OP_POP, '1, '1, '1, 1'b1, reply_of(0, 0, 0, 0, ST_EMPTY, 0)));
    table_rows.push_back(step(OP_SPARE_LO, '1, '1, '1, 1'b1, reply_of(0, 0, 0, 0, ST_OK, 0)));
    table_rows.push_back(step(OP_SPARE_MID, '0, '0, '0, 1'b1, reply_of(0, 0, 0, 0, ST_OK, 0)));
    table_rows.push_back(step(OP_INSERT, 16'h0001, 8'h40, 3'd4, 1'b1,
                              reply_of(0, 0, 0, 0, ST_OK, 1)));
    table_rows.push_back(step(OP_PUSH_TAIL, '0, '0, '0, 1'b1, reply_of(0, 0, 0, 0, ST_OK, 2)));
    table_rows.push_back(step(OP_PUSH_HEAD, '1, '1, '1, 1'b1, reply_of(0, 0, 0, 0, ST_OK, 3)));
    table_rows.push_back(step(OP_PEEK, '0, '0, '0, 1'b1,
                              reply_of(1, 16'hffff, 8'hff, 3'd7, ST_OK, 3)));
    table_rows.push_back(step(OP_INSERT, 16'h1111, 8'h80, 3'd3, 1'b0, none));
    table_rows.push_back(step(OP_INSERT, 16'h2222, 8'hff, 3'd0, 1'b0, none));
    table_rows.push_back(step(OP_INSERT, 16'h3333, 8'h40, 3'd5, 1'b0, none));
    table_rows.push_back(step(OP_INSERT, 16'h4444, 8'h40, 3'd1, 1'b0, none));
    table_rows.push_back(step(OP_SPARE_HI, 16'h5555, 8'h55, 3'd2, 1'b0, none));
    table_rows.push_back(step(OP_POP, '0, '0, '0, 1'b0, none));
    table_rows.push_back(step(OP_POP, '0, '0, '0, 1'b0, none));
    table_rows.push_back(step(OP_PEEK, '0, '0, '0, 1'b0, none));
    foreach (table_rows[i])
      send_request(table_rows[i].mode, table_rows[i].entry, table_rows[i].typed_in,
                   table_rows[i].reply);

    // Fill the queue, then every kind of insert must be refused.
    while (held_entries.size() < QUEUE_DEPTH)
      send_request(OP_INSERT, random_entry(), 1'b0, none);
    send_request(OP_PUSH_TAIL, random_entry(), 1'b1,
                 reply_of(0, 0, 0, 0, ST_FULL, OCC_W'(QUEUE_DEPTH)));
    send_request(OP_PUSH_HEAD, random_entry(), 1'b1,
                 reply_of(0, 0, 0, 0, ST_FULL, OCC_W'(QUEUE_DEPTH)));
    send_request(OP_INSERT, random_entry(), 1'b1,
                 reply_of(0, 0, 0, 0, ST_FULL, OCC_W'(QUEUE_DEPTH)));

    // Random phases, each under its own key select and fill bias.
    for (int phase = 0; phase < PHASES; phase++) begin
      set_order(order_plan[phase]);
      steady = (phase == 3);
      case (phase % 3)
        0:       fill_bias = 70;
        1:       fill_bias = 35;
        default: fill_bias = 52;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
        send_request(random_mode(fill_bias), random_entry(), 1'b0, none);
      end
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Reply side: random back-pressure, and each reply checked against the oldest one due.
  initial begin : reply_sink
    int     stall;
    reply_t seen;
    reply_t due;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen = reply_of(out_head_valid, out_head_tag, out_head_articles, out_head_class,
                      status_t'(out_status), out_occupancy);
      if (pending_replies.size() == 0) begin
        note_fault($sformatf("reply with none due: hv=%0d tag=%h art=%0d cls=%0d st=%0d occ=%0d",
                             seen.head_valid, seen.head_tag, seen.head_articles,
                             seen.head_class, seen.status, seen.occupancy));
      end else begin
        due = pending_replies.pop_front();
        if (seen.head_valid !== due.head_valid || seen.head_tag !== due.head_tag ||
            seen.head_articles !== due.head_articles ||
            seen.head_class !== due.head_class || seen.status !== due.status ||
            seen.occupancy !== due.occupancy)
          note_fault($sformatf(
              "reply mismatch: want hv=%0d tag=%h art=%0d cls=%0d st=%0d occ=%0d, got hv=%0d tag=%h art=%0d cls=%0d st=%0d occ=%0d",
              due.head_valid, due.head_tag, due.head_articles, due.head_class,
              due.status, due.occupancy, seen.head_valid, seen.head_tag,
              seen.head_articles, seen.head_class, seen.status, seen.occupancy));
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
